### rtl/mlfd_pkg.sv
package mlfd_pkg;

    localparam int MAX_LEVELS = 8;
    localparam int FIFO_DEPTH = 16;
    localparam int NUM_CPUS   = 4;
    localparam int PID_BITS   = 8;

    localparam int LVL_W   = $clog2(MAX_LEVELS);
    localparam int NLEV_W  = $clog2(MAX_LEVELS + 1);
    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int CPU_W   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int ADDR_W  = LVL_W + PTR_W;
    localparam int RES_W   = $clog2(NUM_CPUS + 1);

    localparam logic [1:0] MODE_ARRIVAL = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_EXPIRY  = 2'd2;

    localparam logic [1:0] ST_NONE     = 2'd0;
    localparam logic [1:0] ST_DISPATCH = 2'd1;
    localparam logic [1:0] ST_ENQUEUE  = 2'd2;
    localparam logic [1:0] ST_DROP     = 2'd3;

    localparam logic [1:0] REG_LEVELS = 2'd0;
    localparam logic [1:0] REG_BASE_Q = 2'd1;
    localparam logic [1:0] REG_RT_Q   = 2'd2;
    localparam logic [1:0] REG_PERIOD = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  proc_id;
        logic        is_realtime;
        logic [2:0]  current_level;
        logic [3:0]  cpu_idle_mask;
        logic [31:0] clock_now;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  cpu_index;
        logic [7:0]  out_proc_id;
        logic [2:0]  out_level;
        logic [15:0] quantum;
        logic [15:0] mitigated_count;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero_rem;
    } div_rsp_t;

endpackage

### rtl/mlfd_mod_unit.sv
module mlfd_mod_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  mlfd_pkg::div_req_t req,
    output mlfd_pkg::div_rsp_t rsp
);

    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[15:0], quo_reg[31]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[30:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
            end else begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.zero_rem = (rem_reg == '0);

endmodule

### rtl/multilevel_feedback_dispatcher.sv
// Multilevel feedback dispatcher.
// Input channel s_valid/s_ready/s_data carries events: arrival, scheduling tick
// or quantum expiry. Result channel m_valid/m_ready/m_data returns one result
// per arrival or expiry, and one result per dispatch on a tick (up to
// NUM_CPUS), or a single no-dispatch result; last marks the final result.
// Config writes (cfg_we, cfg_index, cfg_wdata) take effect at once; the user
// must make them only while the block is idle (not enforced by the block).
// Timing: one item at a time, s_ready is high only in the idle state.
// Arrival/expiry: the item is registered, then S_ENQ loads its result into
// the output register and returns to idle. A tick scans levels on one
// sequencer: per level S_LVL, S_CPU for each CPU, S_LEND, plus S_RD
// (registered memory read) and S_EMIT per dispatch; S_FIN, S_DRAIN follow.
// A nonzero mitigation period first runs the shift-subtract remainder unit.
// Dispatches are collected first so every result carries the final counter.
// A stalled receiver holds the current result in the output register and the
// sequencer waits for it; new input is taken once the last result is loaded.
// Reset (aresetn, synchronous, active low) empties all level FIFOs, clears
// the mitigation counter and restores register defaults; FIFO storage
// itself is not cleared, only its pointers.
module multilevel_feedback_dispatcher (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mlfd_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mlfd_pkg::out_item_t  m_data,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_wdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ENQ   = 4'd1;
    localparam logic [3:0] S_DIVW  = 4'd2;
    localparam logic [3:0] S_LVL   = 4'd3;
    localparam logic [3:0] S_CPU   = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_EMIT  = 4'd6;
    localparam logic [3:0] S_LEND  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_DRAIN = 4'd9;

    localparam int LW = mlfd_pkg::LVL_W;
    localparam int CW = mlfd_pkg::CPU_W;
    localparam int PW = mlfd_pkg::PTR_W;
    localparam int NW = mlfd_pkg::CNT_W;
    localparam int RW = mlfd_pkg::RES_W;
    localparam int NLW_W = mlfd_pkg::NLEV_W;

    logic [3:0]  levels_reg;
    logic [11:0] base_q_reg;
    logic [15:0] rt_q_reg;
    logic [15:0] period_reg;

    logic [3:0]  state_reg, state_next;
    mlfd_pkg::in_item_t item_reg;
    logic [LW-1:0] lvl_reg, lvl_next;
    logic [LW:0]   steps_reg, steps_next;
    logic [CW:0]   cpu_reg, cpu_next;
    logic [3:0]    idle_reg, idle_next;
    logic          bup_reg, bup_next;
    logic [RW-1:0] nres_reg, nres_next;
    logic [RW-1:0] drain_reg, drain_next;
    logic [15:0]   mcnt_reg, mcnt_next;

    logic [PW-1:0] head_reg [mlfd_pkg::MAX_LEVELS];
    logic [NW-1:0] count_reg [mlfd_pkg::MAX_LEVELS];

    logic [mlfd_pkg::PID_BITS-1:0] mem [mlfd_pkg::MAX_LEVELS * mlfd_pkg::FIFO_DEPTH];
    logic [mlfd_pkg::PID_BITS-1:0] rd_data_reg;
    logic          mem_we;
    logic [mlfd_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
    logic          do_push, do_pop;
    logic [LW-1:0] enq_lvl;

    mlfd_pkg::out_item_t disp_reg [mlfd_pkg::NUM_CPUS];
    mlfd_pkg::out_item_t disp_item;
    logic                disp_we;

    mlfd_pkg::out_item_t out_reg, out_next;
    logic          mvalid_reg, mvalid_next;

    mlfd_pkg::div_req_t div_req;
    mlfd_pkg::div_rsp_t div_rsp;

    logic [NLW_W-1:0] nlev;
    logic [LW-1:0]    last_lvl;
    logic [27:0]      qprod;
    logic [15:0]      qsat;

    mlfd_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        if (levels_reg < 4'd2) begin
            nlev = NLW_W'(2);
        end else if (32'(levels_reg) > mlfd_pkg::MAX_LEVELS) begin
            nlev = NLW_W'(mlfd_pkg::MAX_LEVELS);
        end else begin
            nlev = NLW_W'(levels_reg);
        end
        last_lvl = LW'(nlev - NLW_W'(1));
        qprod = 28'(base_q_reg) * 28'(lvl_reg);
        if (lvl_reg == '0) begin
            qsat = rt_q_reg;
        end else if (qprod > 28'd65535) begin
            qsat = 16'hFFFF;
        end else begin
            qsat = qprod[15:0];
        end
        if (item_reg.mode == mlfd_pkg::MODE_ARRIVAL) begin
            enq_lvl = item_reg.is_realtime ? LW'(0) : LW'(1);
        end else if ({1'b0, item_reg.current_level} + 4'd1 > 4'(nlev) - 4'd1) begin
            enq_lvl = last_lvl;
        end else begin
            enq_lvl = LW'(item_reg.current_level + 3'd1);
        end
        disp_item = '0;
        disp_item.status = mlfd_pkg::ST_DISPATCH;
        disp_item.cpu_index = 2'(cpu_reg[CW-1:0]);
        disp_item.out_proc_id = 8'(rd_data_reg);
        disp_item.out_level = 3'(lvl_reg);
        disp_item.quantum = qsat;
    end

    always_comb begin
        state_next  = state_reg;
        lvl_next    = lvl_reg;
        steps_next  = steps_reg;
        cpu_next    = cpu_reg;
        idle_next   = idle_reg;
        bup_next    = bup_reg;
        nres_next   = nres_reg;
        drain_next  = drain_reg;
        mcnt_next   = mcnt_reg;
        out_next    = out_reg;
        mvalid_next = mvalid_reg;
        do_push     = 1'b0;
        do_pop      = 1'b0;
        disp_we     = 1'b0;
        div_req     = '0;
        div_req.dividend = item_reg.clock_now;
        div_req.divisor  = period_reg;
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    nres_next = '0;
                    idle_next = s_data.cpu_idle_mask;
                    if (s_data.mode == mlfd_pkg::MODE_ARRIVAL ||
                        s_data.mode == mlfd_pkg::MODE_EXPIRY) begin
                        state_next = S_ENQ;
                    end else if (s_data.mode == mlfd_pkg::MODE_TICK) begin
                        if (period_reg != '0) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = s_data.clock_now;
                            state_next = S_DIVW;
                        end else begin
                            bup_next   = 1'b0;
                            lvl_next   = '0;
                            steps_next = (LW+1)'(nlev);
                            state_next = S_LVL;
                        end
                    end else begin
                        state_next = S_FIN;
                    end
                end
            end
            S_ENQ: begin
                if (!mvalid_reg || m_ready) begin
                    do_push = (count_reg[enq_lvl] < NW'(mlfd_pkg::FIFO_DEPTH));
                    out_next = '0;
                    out_next.status = do_push ? mlfd_pkg::ST_ENQUEUE : mlfd_pkg::ST_DROP;
                    out_next.out_proc_id = item_reg.proc_id;
                    out_next.out_level = 3'(enq_lvl);
                    out_next.mitigated_count = mcnt_reg;
                    out_next.last = 1'b1;
                    mvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    bup_next = div_rsp.zero_rem;
                    if (div_rsp.zero_rem) begin
                        lvl_next   = last_lvl;
                        steps_next = (LW+1)'(nlev - NLW_W'(1));
                    end else begin
                        lvl_next   = '0;
                        steps_next = (LW+1)'(nlev);
                    end
                    state_next = S_LVL;
                end
            end
            S_LVL: begin
                if (steps_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    cpu_next   = '0;
                    state_next = S_CPU;
                end
            end
            S_CPU: begin
                if (cpu_reg == (CW+1)'(mlfd_pkg::NUM_CPUS)) begin
                    state_next = S_LEND;
                end else if (idle_reg[cpu_reg[CW-1:0]] && count_reg[lvl_reg] != '0 &&
                             32'(nres_reg) < mlfd_pkg::NUM_CPUS) begin
                    do_pop = 1'b1;
                    idle_next[cpu_reg[CW-1:0]] = 1'b0;
                    state_next = S_RD;
                end else begin
                    cpu_next = cpu_reg + (CW+1)'(1);
                end
            end
            S_RD: begin
                state_next = S_EMIT;
            end
            S_EMIT: begin
                disp_we    = 1'b1;
                nres_next  = nres_reg + RW'(1);
                cpu_next   = cpu_reg + (CW+1)'(1);
                state_next = S_CPU;
            end
            S_LEND: begin
                if (count_reg[lvl_reg] != '0 && mcnt_reg != 16'hFFFF) begin
                    mcnt_next = mcnt_reg + 16'd1;
                end
                lvl_next   = bup_reg ? lvl_reg - LW'(1) : lvl_reg + LW'(1);
                steps_next = steps_reg - (LW+1)'(1);
                state_next = S_LVL;
            end
            S_FIN: begin
                if (nres_reg == '0) begin
                    if (!mvalid_reg || m_ready) begin
                        out_next = '0;
                        out_next.mitigated_count = mcnt_reg;
                        out_next.last = 1'b1;
                        mvalid_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end else begin
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // collected dispatches go out with the final counter value
                if (!mvalid_reg || m_ready) begin
                    out_next = disp_reg[drain_reg[CW-1:0]];
                    out_next.mitigated_count = mcnt_reg;
                    out_next.last = (drain_reg + RW'(1) == nres_reg);
                    mvalid_next = 1'b1;
                    drain_next = drain_reg + RW'(1);
                    if (drain_reg + RW'(1) == nres_reg) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = do_push;
        mem_waddr = {enq_lvl, PW'(head_reg[enq_lvl] + PW'(count_reg[enq_lvl]))};
        mem_raddr = {lvl_reg, head_reg[lvl_reg]};
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= item_reg.proc_id[mlfd_pkg::PID_BITS-1:0];
        end
        if (do_pop) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
            mcnt_reg   <= '0;
            nres_reg   <= '0;
            levels_reg <= 4'd4;
            base_q_reg <= 12'd10;
            rt_q_reg   <= 16'd5;
            period_reg <= 16'd0;
            for (int l = 0; l < mlfd_pkg::MAX_LEVELS; l++) begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            mcnt_reg   <= mcnt_next;
            nres_reg   <= nres_next;
            if (cfg_we) begin
                case (cfg_index)
                    mlfd_pkg::REG_LEVELS: levels_reg <= cfg_wdata[3:0];
                    mlfd_pkg::REG_BASE_Q: base_q_reg <= cfg_wdata[11:0];
                    mlfd_pkg::REG_RT_Q:   rt_q_reg   <= cfg_wdata;
                    mlfd_pkg::REG_PERIOD: period_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (do_push) begin
                count_reg[enq_lvl] <= count_reg[enq_lvl] + NW'(1);
            end
            if (do_pop) begin
                head_reg[lvl_reg]  <= head_reg[lvl_reg] + PW'(1);
                count_reg[lvl_reg] <= count_reg[lvl_reg] - NW'(1);
            end
        end
        if (state_reg == S_IDLE && s_valid) begin
            item_reg <= s_data;
        end
        if (disp_we) begin
            disp_reg[nres_reg[CW-1:0]] <= disp_item;
        end
        out_reg   <= out_next;
        lvl_reg   <= lvl_next;
        steps_reg <= steps_next;
        cpu_reg   <= cpu_next;
        idle_reg  <= idle_next;
        bup_reg   <= bup_next;
        drain_reg <= drain_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mvalid_reg;
    assign m_data  = out_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (state_reg == S_IDLE))
        else $error("ready outside idle");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push |-> (count_reg[enq_lvl] < NW'(mlfd_pkg::FIFO_DEPTH)))
        else $error("push into full fifo");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |-> (count_reg[lvl_reg] != '0))
        else $error("pop from empty fifo");

    a_mcnt_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (mcnt_reg >= $past(mcnt_reg)))
        else $error("mitigation counter decreased");

endmodule

### tb/mlfd_checker.sv
`timescale 1ns / 1ps

module mlfd_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  mlfd_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  mlfd_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    output int                  pending,
    output int                  errors
);

    logic [3:0]  levels_reg;
    logic [11:0] base_q_reg;
    logic [15:0] rt_q_reg;
    logic [15:0] period_reg;

    logic [7:0]  queue_mem [mlfd_pkg::MAX_LEVELS][mlfd_pkg::FIFO_DEPTH];
    int          q_head [mlfd_pkg::MAX_LEVELS];
    int          q_count [mlfd_pkg::MAX_LEVELS];
    logic [15:0] starve_cnt;

    mlfd_pkg::out_item_t sched_expected [$];

    assign pending = sched_expected.size();

    function automatic int live_levels();
        int n;
        n = levels_reg;
        if (n < 2) n = 2;
        if (n > mlfd_pkg::MAX_LEVELS) n = mlfd_pkg::MAX_LEVELS;
        return n;
    endfunction

    function automatic logic [15:0] slice_for(int lvl);
        int q;
        q = (lvl == 0) ? int'(rt_q_reg) : int'(base_q_reg) * lvl;
        return (q > 65535) ? 16'hFFFF : q[15:0];
    endfunction

    task automatic place(int lvl, logic [7:0] pid, ref mlfd_pkg::out_item_t res[$]);
        mlfd_pkg::out_item_t r;
        r = '0;
        r.out_proc_id = pid;
        r.out_level   = lvl[2:0];
        if (q_count[lvl] >= mlfd_pkg::FIFO_DEPTH) begin
            r.status = mlfd_pkg::ST_DROP;
        end else begin
            queue_mem[lvl][(q_head[lvl] + q_count[lvl]) % mlfd_pkg::FIFO_DEPTH] = pid;
            q_count[lvl]++;
            r.status = mlfd_pkg::ST_ENQUEUE;
        end
        res.insert(res.size(), r);
    endtask

    task automatic schedule(mlfd_pkg::in_item_t it);
        mlfd_pkg::out_item_t res [$];
        mlfd_pkg::out_item_t r;
        int nlev, steps, lvl, nxt;
        logic [3:0] idle;
        bit up;
        nlev = live_levels();
        idle = it.cpu_idle_mask;
        if (it.mode == mlfd_pkg::MODE_ARRIVAL) begin
            place(it.is_realtime ? 0 : 1, it.proc_id, res);
        end else if (it.mode == mlfd_pkg::MODE_EXPIRY) begin
            nxt = it.current_level + 1;
            if (nxt > nlev - 1) nxt = nlev - 1;
            place(nxt, it.proc_id, res);
        end else if (it.mode == mlfd_pkg::MODE_TICK) begin
            up = period_reg != 0 && (it.clock_now % period_reg) == 0;
            steps = up ? nlev - 1 : nlev;
            for (int s = 0; s < steps; s++) begin
                lvl = up ? nlev - 1 - s : s;
                for (int c = 0; c < mlfd_pkg::NUM_CPUS; c++) begin
                    if (idle[c] && q_count[lvl] != 0 && res.size() < mlfd_pkg::NUM_CPUS) begin
                        r = '0;
                        r.status      = mlfd_pkg::ST_DISPATCH;
                        r.cpu_index   = c[1:0];
                        r.out_proc_id = queue_mem[lvl][q_head[lvl]];
                        r.out_level   = lvl[2:0];
                        r.quantum     = slice_for(lvl);
                        q_head[lvl]   = (q_head[lvl] + 1) % mlfd_pkg::FIFO_DEPTH;
                        q_count[lvl]--;
                        idle[c] = 1'b0;
                        res.insert(res.size(), r);
                    end
                end
                if (q_count[lvl] != 0 && starve_cnt != 16'hFFFF) starve_cnt++;
            end
        end
        if (res.size() == 0) begin
            r = '0;
            res.insert(0, r);
        end
        foreach (res[k]) begin
            res[k].mitigated_count = starve_cnt;
            res[k].last = (k == res.size() - 1);
            sched_expected.insert(sched_expected.size(), res[k]);
        end
    endtask

    always @(posedge aclk) begin
        mlfd_pkg::out_item_t e;
        if (!aresetn) begin
            levels_reg = 4'd4;
            base_q_reg = 12'd10;
            rt_q_reg   = 16'd5;
            period_reg = 16'd0;
            starve_cnt = '0;
            for (int l = 0; l < mlfd_pkg::MAX_LEVELS; l++) begin
                q_head[l]  = 0;
                q_count[l] = 0;
            end
            sched_expected.delete();
            errors = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    mlfd_pkg::REG_LEVELS: levels_reg = cfg_wdata[3:0];
                    mlfd_pkg::REG_BASE_Q: base_q_reg = cfg_wdata[11:0];
                    mlfd_pkg::REG_RT_Q:   rt_q_reg   = cfg_wdata;
                    mlfd_pkg::REG_PERIOD: period_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) schedule(s_data);
            if (m_valid && m_ready) begin
                if (sched_expected.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, m_data);
                    errors++;
                end else begin
                    e = sched_expected.pop_front();
                    if (m_data.status !== e.status || m_data.cpu_index !== e.cpu_index ||
                        m_data.out_proc_id !== e.out_proc_id ||
                        m_data.out_level !== e.out_level || m_data.quantum !== e.quantum ||
                        m_data.mitigated_count !== e.mitigated_count ||
                        m_data.last !== e.last) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, m_data);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_WAIT  = 120;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    mlfd_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    mlfd_pkg::out_item_t m_data;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = mlfd_pkg::REG_LEVELS;
    logic [15:0]         cfg_wdata = '0;
    int                  pending;
    int                  errors;
    int                  quiet_cycles = 0;
    int                  results_seen = 0;
    int                  hold_left = 0;
    logic [15:0]         cur_period = 16'd0;

    always #5 aclk = ~aclk;

    multilevel_feedback_dispatcher u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    mlfd_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .pending(pending), .errors(errors)
    );

    // receiver: pattern cycles through three styles over time, one long hold after 100 transfers
    always @(posedge aclk) begin
        int style;
        style = int'(($time / 640) % 3);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (results_seen == 100) hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (style == 0) begin
                m_ready <= 1'b1;
            end else if (style == 1) begin
                m_ready <= 1'($urandom_range(0, 1));
            end else begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send(mlfd_pkg::in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_regs(logic [15:0] lv, logic [15:0] bq, logic [15:0] rq,
                            logic [15:0] per);
        wait_drained();
        cfg_we <= 1'b1; cfg_index <= mlfd_pkg::REG_LEVELS; cfg_wdata <= lv; @(posedge aclk);
        cfg_index <= mlfd_pkg::REG_BASE_Q; cfg_wdata <= bq;                @(posedge aclk);
        cfg_index <= mlfd_pkg::REG_RT_Q;   cfg_wdata <= rq;                @(posedge aclk);
        cfg_index <= mlfd_pkg::REG_PERIOD; cfg_wdata <= per;               @(posedge aclk);
        cfg_we <= 1'b0;
        cur_period = per;
    endtask

    function automatic mlfd_pkg::in_item_t make_event(logic [1:0] md, logic [7:0] pid,
                                                      logic rt, logic [2:0] lvl,
                                                      logic [3:0] mask, logic [31:0] clk);
        mlfd_pkg::in_item_t it;
        it.mode = md; it.proc_id = pid; it.is_realtime = rt;
        it.current_level = lvl; it.cpu_idle_mask = mask; it.clock_now = clk;
        return it;
    endfunction

    function automatic mlfd_pkg::in_item_t random_event();
        mlfd_pkg::in_item_t it;
        logic [63:0] raw;
        int pick;
        raw = {$urandom, $urandom};
        it = raw[$bits(mlfd_pkg::in_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 45) it.mode = mlfd_pkg::MODE_ARRIVAL;
        else if (pick < 65) it.mode = mlfd_pkg::MODE_EXPIRY;
        else if (pick < 95) it.mode = mlfd_pkg::MODE_TICK;
        else it.mode = 2'd3;
        if ($urandom_range(0, 2) == 0) it.cpu_idle_mask = 4'hF;
        if (cur_period != 0 && $urandom_range(0, 1) == 0)
            it.clock_now = cur_period * $urandom_range(0, 65535);
        return it;
    endfunction

    task automatic random_phase(int count);
        int done_items;
        done_items = 0;
        while (done_items < count) begin
            repeat ($urandom_range(1, 8)) begin
                if (done_items < count) begin
                    send(random_event());
                    done_items++;
                end
            end
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send(make_event(mlfd_pkg::MODE_ARRIVAL, 8'd0,  1'b0, 3'd0, 4'h0, 32'd0));
        send(make_event(mlfd_pkg::MODE_ARRIVAL, 8'hFF, 1'b1, 3'd0, 4'h0, 32'd0));
        send(make_event(mlfd_pkg::MODE_ARRIVAL, 8'h5A, 1'b0, 3'd0, 4'h0, 32'd0));
        send(make_event(mlfd_pkg::MODE_TICK,    8'd0,  1'b0, 3'd0, 4'h0, 32'hFFFFFFFF));
        send(make_event(mlfd_pkg::MODE_TICK,    8'd0,  1'b0, 3'd0, 4'hF, 32'd0));
        send(make_event(mlfd_pkg::MODE_EXPIRY,  8'hA5, 1'b0, 3'd0, 4'h0, 32'd0));
        send(make_event(mlfd_pkg::MODE_EXPIRY,  8'h3C, 1'b0, 3'd7, 4'h0, 32'd0));
        send(make_event(mlfd_pkg::MODE_EXPIRY,  8'hC3, 1'b1, 3'd2, 4'hF, 32'hFFFFFFFF));
        send(make_event(2'd3,                   8'hFF, 1'b1, 3'd7, 4'hF, 32'hFFFFFFFF));
        send(make_event(mlfd_pkg::MODE_TICK,    8'hFF, 1'b1, 3'd7, 4'h5, 32'h12345678));
        send(make_event(mlfd_pkg::MODE_TICK,    8'd0,  1'b0, 3'd0, 4'hA, 32'd7));
        send(make_event(mlfd_pkg::MODE_TICK,    8'd0,  1'b0, 3'd0, 4'hF, 32'd9));
        send(make_event(mlfd_pkg::MODE_TICK,    8'd0,  1'b0, 3'd0, 4'hF, 32'd9));

        random_phase(50);
        set_regs(16'd2, 16'd1, 16'd1, 16'd0);
        random_phase(50);
        set_regs(16'd8, 16'd4095, 16'd65535, 16'd1);
        random_phase(50);
        set_regs(16'd0, 16'd7, 16'd0, 16'd3);
        random_phase(50);
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(50);
        set_regs(16'd5, 16'd3, 16'd100, 16'd4);
        random_phase(50);
        set_regs(16'd1, 16'd2048, 16'd7, 16'd2);
        random_phase(50);
        set_regs(16'd9, 16'd10, 16'd5, 16'd0);
        random_phase(50);

        wait_drained();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
